[rtl/tsf_pkg.sv]
`timescale 1ns / 1ps

package tsf_pkg;

  localparam logic [15:0] HEADER_BYTES  = 16'd20;
  localparam logic [7:0]  TS_KIND       = 8'd8;
  localparam int          MIN_REMAIN    = 10;
  localparam logic [3:0]  TS_LAST_INDEX = 4'd9;
  localparam logic [3:0]  TS_VALUE_END  = 4'd5;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  // bound offsets: kind byte needs pos + 1 + 10, length byte needs pos - 1 + length + 10
  localparam logic [16:0] KIND_GAP = 17'(1 + MIN_REMAIN);
  localparam logic [16:0] LEN_GAP  = 17'(MIN_REMAIN - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_LEN,
    PH_CAPTURE
  } phase_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_MISS,
    OUT_HIT
  } outcome_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] total_length;
    logic [15:0] pos;
    logic [16:0] pos_len;
    logic        kind_fail;
  } beat_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  option_kind;
    logic [7:0]  option_length;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
  } result_t;

endpackage

[rtl/tsf_front.sv]
`timescale 1ns / 1ps

module tsf_front
  import tsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] total_length,
  output logic        beat_valid,
  input  logic        beat_ready,
  output beat_t       beat
);

  logic [15:0] pos_cnt;
  logic [15:0] pos;
  logic        take;

  assign in_ready = !beat_valid || beat_ready;
  assign take     = in_valid && in_ready;
  assign pos      = first_byte ? 16'd0 : pos_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt    <= 16'd0;
      beat_valid <= 1'b0;
    end else begin
      if (take) begin
        pos_cnt    <= (pos == POS_MAX) ? POS_MAX : pos + 16'd1;
        beat_valid <= 1'b1;
      end else if (beat_ready) begin
        beat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat.data         <= data_byte;
      beat.first        <= first_byte;
      beat.last         <= last_byte;
      beat.total_length <= total_length;
      beat.pos          <= pos;
      beat.pos_len      <= {1'b0, pos} + LEN_GAP;
      beat.kind_fail    <= ({1'b0, pos} + KIND_GAP) > {1'b0, total_length};
    end
  end

endmodule

[rtl/tsf_queue.sv]
`timescale 1ns / 1ps

module tsf_queue
  import tsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  beat_t push_beat,
  output logic  pop_valid,
  input  logic  pop_ready,
  output beat_t pop_beat
);

  beat_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  push;
  logic                  pop;

  assign push_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_beat   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_beat;
  end

endmodule

[rtl/tsf_back.sv]
`timescale 1ns / 1ps

module tsf_back
  import tsf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    beat_valid,
  output logic    beat_ready,
  input  beat_t   beat,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  logic [15:0] next_option_start, next_option_start_next;
  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  capture_count, capture_count_next;
  logic [7:0]  held_length, held_length_next;
  logic [31:0] value_shift, value_shift_next;
  logic [31:0] echo_shift, echo_shift_next;
  logic        resolved, resolved_next;
  outcome_t    outcome;
  logic        step;
  logic        len_fail;
  logic [15:0] len_target;

  assign beat_ready = !out_valid || out_ready;
  assign step       = beat_valid && beat_ready;
  assign len_fail   = ({1'b0, beat.pos_len} + {10'd0, beat.data}) > {2'b0, beat.total_length};
  assign len_target = beat.pos + {8'd0, beat.data} - 16'd1;

  always_comb begin
    next_option_start_next = next_option_start;
    parse_phase_next       = parse_phase;
    capture_count_next     = capture_count;
    held_length_next       = held_length;
    value_shift_next       = value_shift;
    echo_shift_next        = echo_shift;
    resolved_next          = resolved;
    outcome                = OUT_NONE;

    if (beat.first) begin
      next_option_start_next = HEADER_BYTES;
      parse_phase_next       = PH_WAIT;
      capture_count_next     = 4'd0;
      held_length_next       = 8'd0;
      value_shift_next       = 32'd0;
      echo_shift_next        = 32'd0;
      resolved_next          = 1'b0;
    end

    if (!resolved_next) begin
      unique case (parse_phase_next)
        PH_WAIT: begin
          if (beat.pos == next_option_start_next) begin
            if (beat.data <= 8'd1) begin
              if (beat.kind_fail) outcome = OUT_MISS;
              else next_option_start_next = beat.pos + 16'd1;
            end else if (beat.data == TS_KIND) begin
              parse_phase_next   = PH_CAPTURE;
              capture_count_next = 4'd0;
              held_length_next   = 8'd0;
              value_shift_next   = 32'd0;
              echo_shift_next    = 32'd0;
            end else begin
              parse_phase_next = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (beat.data == 8'd0 || len_fail) begin
            outcome = OUT_MISS;
          end else if (beat.data == 8'd1) begin
            // a length of one is re-read as a one-byte kind
            if (beat.kind_fail) begin
              outcome = OUT_MISS;
            end else begin
              next_option_start_next = beat.pos + 16'd1;
              parse_phase_next       = PH_WAIT;
            end
          end else begin
            next_option_start_next = len_target;
            parse_phase_next       = PH_WAIT;
          end
        end
        PH_CAPTURE: begin
          capture_count_next = capture_count_next + 4'd1;
          if (capture_count_next == 4'd1)
            held_length_next = beat.data;
          else if (capture_count_next <= TS_VALUE_END)
            value_shift_next = {value_shift_next[23:0], beat.data};
          else
            echo_shift_next = {echo_shift_next[23:0], beat.data};
          if (capture_count_next == TS_LAST_INDEX) outcome = OUT_HIT;
        end
        default: begin
          parse_phase_next = PH_WAIT;
        end
      endcase
      if (outcome == OUT_NONE && beat.last) outcome = OUT_MISS;
      if (outcome != OUT_NONE) resolved_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_option_start <= HEADER_BYTES;
      parse_phase       <= PH_WAIT;
      capture_count     <= 4'd0;
      held_length       <= 8'd0;
      value_shift       <= 32'd0;
      echo_shift        <= 32'd0;
      resolved          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (step) begin
        next_option_start <= next_option_start_next;
        parse_phase       <= parse_phase_next;
        capture_count     <= capture_count_next;
        held_length       <= held_length_next;
        value_shift       <= value_shift_next;
        echo_shift        <= echo_shift_next;
        resolved          <= resolved_next;
      end
      if (step && outcome != OUT_NONE) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && outcome != OUT_NONE) begin
      if (outcome == OUT_HIT) begin
        result.found         <= 1'b1;
        result.option_kind   <= TS_KIND;
        result.option_length <= held_length_next;
        result.ts_value      <= value_shift_next;
        result.ts_echo       <= echo_shift_next;
      end else begin
        result <= '0;
      end
    end
  end

endmodule

[rtl/tcp_timestamp_option_finder.sv]
`timescale 1ns / 1ps

// Scans a TCP segment for the timestamp option.
// Input channel (in_valid/in_ready): one segment byte per beat, with first_byte,
// last_byte and the stated total_length on every beat.
// Output channel (out_valid/out_ready): one result beat per settled segment, either the
// timestamp option (found, kind, length, value, echo) or all zeros for not found.
// Bytes after a segment is settled are dropped until the next first_byte.
// Throughput: one byte per cycle, sustained while the receiver keeps out_ready high.
// The byte that settles the segment passes through the front register and the byte
// queue, and its result is then held in the result register.
// A 4-entry byte queue sits between the classifying front end and the option
// walker, so a stalled receiver backs up through the queue before in_ready drops.
// The result register holds while out_ready is low; the walker stalls behind it.
// Reset (rst, synchronous) empties the queue and result register and treats the
// next byte as the start of a segment.
module tcp_timestamp_option_finder
  import tsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] total_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  option_kind,
  output logic [7:0]  option_length,
  output logic [31:0] ts_value,
  output logic [31:0] ts_echo
);

  logic    front_valid;
  logic    front_ready;
  beat_t   front_beat;
  logic    queue_valid;
  logic    queue_ready;
  beat_t   queue_beat;
  result_t result;

  tsf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .total_length (total_length),
    .beat_valid   (front_valid),
    .beat_ready   (front_ready),
    .beat         (front_beat)
  );

  tsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_beat  (front_beat),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_beat   (queue_beat)
  );

  tsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (queue_valid),
    .beat_ready (queue_ready),
    .beat       (queue_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign found         = result.found;
  assign option_kind   = result.option_kind;
  assign option_length = result.option_length;
  assign ts_value      = result.ts_value;
  assign ts_echo       = result.ts_echo;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tsf_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] tlen;
  } seg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic [15:0] total_length = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [7:0]  option_kind;
  logic [7:0]  option_length;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;

  tcp_timestamp_option_finder u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .total_length  (total_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .option_kind   (option_kind),
    .option_length (option_length),
    .ts_value      (ts_value),
    .ts_echo       (ts_echo)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("tcp_timestamp_option_finder test failed");
    $finish;
  end

  seg_byte_t   byte_queue[$];
  result_t     expected_ts[$];
  logic [7:0]  seg[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          segs_sent = 0;

  // scanner state
  logic [15:0] scan_pos = 16'd0;
  logic [15:0] opt_start = HEADER_BYTES;
  phase_t      scan_phase = PH_WAIT;
  logic [3:0]  cap_count = 4'd0;
  logic [7:0]  cap_len = 8'd0;
  logic [31:0] cap_value = 32'd0;
  logic [31:0] cap_echo = 32'd0;
  logic        seg_done = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic outcome_t walk_kind(input logic [7:0] b, input int unsigned pos,
                                         input int unsigned tl);
    if (b <= 8'd1) begin
      if (pos + 1 + MIN_REMAIN > tl) return OUT_MISS;
      opt_start = 16'(pos + 1);
      scan_phase = PH_WAIT;
    end else if (b == TS_KIND) begin
      scan_phase = PH_CAPTURE;
      cap_count = 4'd0;
      cap_len = 8'd0;
      cap_value = 32'd0;
      cap_echo = 32'd0;
    end else begin
      scan_phase = PH_LEN;
    end
    return OUT_NONE;
  endfunction

  task automatic ts_scan_byte(input seg_byte_t sb);
    int unsigned pos;
    int unsigned tl;
    int unsigned nxt;
    outcome_t    oc;
    result_t     r;
    oc = OUT_NONE;
    tl = int'(sb.tlen);
    if (sb.first) begin
      scan_pos = 16'd0;
      opt_start = HEADER_BYTES;
      scan_phase = PH_WAIT;
      cap_count = 4'd0;
      cap_len = 8'd0;
      cap_value = 32'd0;
      cap_echo = 32'd0;
      seg_done = 1'b0;
    end
    if (!seg_done) begin
      pos = int'(scan_pos);
      if (scan_pos != POS_MAX) scan_pos = scan_pos + 16'd1;
      case (scan_phase)
        PH_WAIT: begin
          if (pos == int'(opt_start)) oc = walk_kind(sb.data, pos, tl);
        end
        PH_LEN: begin
          if (sb.data == 8'd0) begin
            oc = OUT_MISS;
          end else begin
            nxt = pos - 1 + int'(sb.data);
            if (nxt + MIN_REMAIN > tl) oc = OUT_MISS;
            else if (sb.data == 8'd1) oc = walk_kind(sb.data, pos, tl);
            else begin
              opt_start = 16'(nxt);
              scan_phase = PH_WAIT;
            end
          end
        end
        PH_CAPTURE: begin
          cap_count = cap_count + 4'd1;
          if (cap_count == 4'd1) cap_len = sb.data;
          else if (cap_count <= TS_VALUE_END) cap_value = {cap_value[23:0], sb.data};
          else cap_echo = {cap_echo[23:0], sb.data};
          if (cap_count == TS_LAST_INDEX) oc = OUT_HIT;
        end
        default: scan_phase = PH_WAIT;
      endcase
      if (oc == OUT_NONE && sb.last) oc = OUT_MISS;
      if (oc != OUT_NONE) begin
        seg_done = 1'b1;
        r = '0;
        if (oc == OUT_HIT) begin
          r.found = 1'b1;
          r.option_kind = TS_KIND;
          r.option_length = cap_len;
          r.ts_value = cap_value;
          r.ts_echo = cap_echo;
        end
        expected_ts.push_back(r);
      end
    end
  endtask

  // driver
  seg_byte_t cur;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) ts_scan_byte(cur);
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = byte_queue.pop_front();
          in_valid <= 1'b1;
          data_byte <= cur.data;
          first_byte <= cur.first;
          last_byte <= cur.last;
          total_length <= cur.tlen;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  result_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ts.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_ts.pop_front();
          check_field("found", 32'(found), 32'(want.found));
          check_field("option_kind", 32'(option_kind), 32'(want.option_kind));
          check_field("option_length", 32'(option_length), 32'(want.option_length));
          check_field("ts_value", ts_value, want.ts_value);
          check_field("ts_echo", ts_echo, want.ts_echo);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put_header();
    repeat (20) seg.push_back(8'($urandom));
  endtask

  task automatic put_ts(input logic [7:0] len, input logic [31:0] val, input logic [31:0] echo);
    seg.push_back(TS_KIND);
    seg.push_back(len);
    for (int i = 3; i >= 0; i--) seg.push_back(val[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) seg.push_back(echo[i*8 +: 8]);
  endtask

  task automatic put_opt(input logic [7:0] kind, input logic [7:0] len);
    seg.push_back(kind);
    seg.push_back(len);
    for (int i = 2; i < int'(len); i++) seg.push_back(8'($urandom));
  endtask

  task automatic emit(input logic [15:0] tl, input bit with_first, input bit with_last);
    seg_byte_t sb;
    for (int i = 0; i < seg.size(); i++) begin
      sb.data = seg[i];
      sb.first = with_first && (i == 0);
      sb.last = with_last && (i == seg.size() - 1);
      sb.tlen = tl;
      byte_queue.push_back(sb);
    end
    items_sent += seg.size();
    segs_sent++;
    seg.delete();
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_segment();
    int          n;
    int          pick;
    int          cut;
    int          tl;
    logic [7:0]  kind;
    logic [7:0]  len;
    put_header();
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        seg.push_back(8'd0);
      end else if (pick < 25) begin
        seg.push_back(8'd1);
      end else if (pick < 55) begin
        kind = 8'($urandom_range(2, 255));
        if (kind == TS_KIND) kind = 8'd9;
        pick = $urandom_range(99);
        if (pick < 85) len = 8'($urandom_range(2, 12));
        else if (pick < 92) len = 8'($urandom_range(1));
        else len = 8'($urandom);
        put_opt(kind, len);
      end else begin
        len = ($urandom_range(99) < 85) ? 8'd10 : 8'($urandom);
        put_ts(len, rand_word(), rand_word());
      end
    end
    repeat ($urandom_range(4)) seg.push_back(8'($urandom));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, seg.size());
      while (seg.size() > cut) void'(seg.pop_back());
    end
    pick = $urandom_range(99);
    if (pick < 70) tl = seg.size();
    else if (pick < 85) tl = seg.size() + $urandom_range(20) - 10;
    else tl = $urandom_range(65535);
    if (tl < 0) tl = 0;
    emit(16'(tl), $urandom_range(19) != 0, $urandom_range(19) != 0);
  endtask

  task automatic rand_noise();
    seg_byte_t sb;
    repeat ($urandom_range(1, 8)) begin
      sb.data = 8'($urandom);
      sb.first = 1'($urandom);
      sb.last = 1'($urandom);
      sb.tlen = 16'($urandom);
      byte_queue.push_back(sb);
      items_sent++;
    end
  endtask

  task automatic directed();
    // stream opens without first_byte
    put_header(); put_ts(8'd10, 32'hFFFF_FFFF, 32'h0000_0000);
    emit(16'd30, 1'b0, 1'b1);
    put_header(); seg.push_back(8'd1); seg.push_back(8'd1);
    put_ts(8'd10, 32'h0000_0000, 32'hFFFF_FFFF); seg.push_back(8'd0);
    emit(16'd33, 1'b1, 1'b1);
    // end-of-list kind walked one byte at a time, then an option skipped by its length
    put_header(); seg.push_back(8'd0); put_opt(8'd2, 8'd4);
    put_ts(8'd10, 32'h1234_5678, 32'h9ABC_DEF0);
    emit(16'd60, 1'b1, 1'b1);
    // zero length byte
    put_header(); put_opt(8'd3, 8'd0); repeat (12) seg.push_back(8'($urandom));
    emit(16'd40, 1'b1, 1'b1);
    // length byte of one
    put_header(); seg.push_back(8'd5); seg.push_back(8'd1);
    put_ts(8'd10, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
    emit(16'd32, 1'b1, 1'b1);
    // bound fails on the first option, a one-byte kind
    put_header(); seg.push_back(8'd1); put_ts(8'd10, 32'h1, 32'h2);
    emit(16'd30, 1'b1, 1'b1);
    // bound fails on a length byte
    put_header(); put_opt(8'd4, 8'd6); put_ts(8'd10, 32'h3, 32'h4);
    emit(16'd35, 1'b1, 1'b1);
    // early end mid-capture
    put_header(); put_ts(8'd10, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    repeat (5) void'(seg.pop_back());
    emit(16'd200, 1'b1, 1'b1);
    // stated length extremes
    put_header(); put_ts(8'd10, 32'h8000_0001, 32'h7FFF_FFFE);
    emit(16'd0, 1'b1, 1'b1);
    put_header(); put_opt(8'd2, 8'd4); put_ts(8'd10, 32'h0102_0304, 32'h0506_0708);
    emit(16'hFFFF, 1'b1, 1'b1);
    // odd timestamp length bytes, then trailing bytes after settling
    put_header(); put_ts(8'd0, 32'h1111_2222, 32'h3333_4444);
    repeat (10) seg.push_back(8'($urandom));
    emit(16'd40, 1'b1, 1'b1);
    put_header(); put_ts(8'hFF, 32'h5555_6666, 32'h7777_8888);
    emit(16'd30, 1'b1, 1'b1);
    // long jump past the end of the bytes
    put_header(); seg.push_back(8'hFF); seg.push_back(8'hFF);
    repeat (3) seg.push_back(8'($urandom));
    emit(16'hFFFF, 1'b1, 1'b1);
    // segments shorter than the header: five bytes and a single byte
    repeat (5) seg.push_back(8'($urandom));
    emit(16'd5, 1'b1, 1'b1);
    seg.push_back(8'hFF);
    emit(16'd1, 1'b1, 1'b1);
    // restart mid-segment without last_byte
    put_header(); put_opt(8'd2, 8'd4);
    emit(16'd50, 1'b1, 1'b0);
    put_header(); put_ts(8'd10, 32'hFEDC_BA98, 32'h7654_3210);
    emit(16'd30, 1'b1, 1'b1);
  endtask

  task automatic random_phase(input int idle, input int stall);
    int start_items;
    int start_segs;
    @(posedge clk);
    send_idle_pct <= idle;
    recv_stall_pct <= stall;
    start_items = items_sent;
    start_segs = segs_sent;
    while (items_sent - start_items < 75 || segs_sent - start_segs < 2) begin
      if ($urandom_range(19) == 0) rand_noise();
      else rand_segment();
    end
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    int waited;
    directed();
    random_phase(0, 0);
    random_phase(60, 0);
    random_phase(0, 60);
    random_phase(13, 13);
    waited = 0;
    while (expected_ts.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_ts.size() != 0)
      report($sformatf("%0d results never arrived", expected_ts.size()));
    if (errors == 0) begin
      $display("tcp_timestamp_option_finder test passed");
    end else begin
      $display("tcp_timestamp_option_finder test failed");
    end
    $finish;
  end

endmodule
